FILE: rtl/sro_pkg.sv
// Shared types and constants for the sequence reorder buffer.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package sro_pkg;

    // Reorder window. The slot of a number is its low SLOT_BITS bits, so the
    // window must be a power of two.
    localparam int WINDOW    = 16;
    localparam int SLOT_BITS = $clog2(WINDOW);

    // Width of the next-hop id held in the route state.
    localparam int HOP_BITS = 8;

    // Most deliveries one message may release, and the delivery queue sizing.
    localparam int MAX_OUT   = 16;
    localparam int QPTR_BITS = $clog2(MAX_OUT);
    localparam int QCNT_BITS = $clog2(MAX_OUT + 1);

    // Expected number saturates here.
    localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_OLD      = 2'd1;
    localparam logic [1:0] ST_BEYOND   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROUTE_IS_DIRECT = 2'd0;
    localparam logic [1:0] CFG_INITIAL_HOP     = 2'd1;

    // One arriving message.
    typedef struct packed {
        logic [31:0] seq_no;
        logic [31:0] payload;
        logic        is_chat;
        logic [7:0]  sender_id;
        logic        from_direct;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [1:0]  status;
        logic        route_updated;
        logic [7:0]  next_hop;
        logic [31:0] expected_seq;
        logic        delivery_valid;
        logic [31:0] delivery_seq;
        logic [31:0] delivery_payload;
        logic        last;
    } out_item_t;

    // One delivered chat message waiting in the queue.
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] payload;
    } dlv_t;

    // Summary of one finished message, handed from front to back.
    typedef struct packed {
        logic [1:0]  status;
        logic        route_updated;
        logic [7:0]  next_hop;
        logic [31:0] expected_seq;
    } step_t;

endpackage

FILE: rtl/sequence_reorder_buffer_unit.sv
// Top level of the sequence reorder buffer: front part, delivery queue, back part.
// Depends on sro_pkg, sro_front, sro_queue and sro_back.
//
// Usage:
//   Messages enter on in_valid/in_ready/in_data; each transfer is one numbered
//   message. Results leave on out_valid/out_ready/out_data; a message yields one
//   result per delivered chat message in number order, or a single result with
//   no delivery, and the final one has last set. The cfg port (cfg_index,
//   cfg_data) writes route_is_direct (0) and initial_hop (1); the user must
//   write them only while idle, which the block itself does not enforce.
//   Writing initial_hop also reloads the current next hop.
//   Steps: the message is taken, then classified and stored, then each ready
//   slot is drained until the end of the run is found, then the summary is
//   handed over; results then leave one per cycle while the receiver takes them.
//   The output register lets the next message be taken while the final result
//   of the previous one still waits for the receiver; a stalled receiver
//   otherwise holds the back part and, through it, the input.
//   Reset empties the slot store, sets the expected number to one and clears
//   the route state; no clearing pass is needed.
module sequence_reorder_buffer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sro_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sro_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic                            back_busy;
    logic                            q_push;
    logic                            q_pop;
    sro_pkg::dlv_t                   q_wdata;
    sro_pkg::dlv_t                   q_rdata;
    logic                            q_full;
    logic                            q_empty;
    logic [sro_pkg::QCNT_BITS-1:0]   q_count;
    logic                            step_valid;
    logic                            step_ready;
    sro_pkg::step_t                  step_data;

    // Classification, slot store and drain.
    sro_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .back_busy  (back_busy),
        .q_push     (q_push),
        .q_wdata    (q_wdata),
        .q_full     (q_full),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step_data  (step_data)
    );

    // Deliveries waiting for the back part.
    sro_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty),
        .count (q_count)
    );

    // Result formatting and output register.
    sro_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step_data  (step_data),
        .busy       (back_busy),
        .q_pop      (q_pop),
        .q_rdata    (q_rdata),
        .q_empty    (q_empty),
        .q_count    (q_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

FILE: rtl/sro_queue.sv
// Delivery queue between the front and back parts of the reorder buffer.
// Depends on sro_pkg for the entry type and depth.
module sro_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  sro_pkg::dlv_t                   wdata,
    input  logic                            pop,
    output sro_pkg::dlv_t                   rdata,
    output logic                            full,
    output logic                            empty,
    output logic [sro_pkg::QCNT_BITS-1:0]   count
);

    sro_pkg::dlv_t                   entry_reg [sro_pkg::MAX_OUT];
    logic [sro_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [sro_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [sro_pkg::QCNT_BITS-1:0]   count_reg;
    logic                            do_push;
    logic                            do_pop;

    // Status flags.
    assign full    = (count_reg == sro_pkg::QCNT_BITS'(sro_pkg::MAX_OUT));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Entry storage; the data needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == sro_pkg::QPTR_BITS'(sro_pkg::MAX_OUT - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == sro_pkg::QPTR_BITS'(sro_pkg::MAX_OUT - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/sro_front.sv
// Front part: accepts messages, classifies them against the window, keeps the
// slot store and route state, and drains ready slots, pushing chat ones into the delivery queue.
// Depends on sro_pkg.
module sro_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sro_pkg::in_item_t in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              back_busy,
    output logic              q_push,
    output sro_pkg::dlv_t     q_wdata,
    input  logic              q_full,
    output logic              step_valid,
    input  logic              step_ready,
    output sro_pkg::step_t    step_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] payload;
        logic        chat;
    } slot_t;

    state_t                          state_reg;
    sro_pkg::in_item_t               item_reg;
    logic                            route_direct_reg;
    logic [31:0]                     expected_reg;
    logic [31:0]                     newest_reg;
    logic [sro_pkg::HOP_BITS-1:0]    hop_reg;
    logic [1:0]                      status_reg;
    logic                            updated_reg;
    logic [sro_pkg::WINDOW-1:0]      slot_full_reg;
    slot_t                           slot_mem [sro_pkg::WINDOW];

    logic [31:0]                     diff;
    logic                            is_old;
    logic                            is_beyond;
    logic [sro_pkg::SLOT_BITS-1:0]   in_slot;
    logic                            take_route;
    logic                            store_item;
    logic [sro_pkg::SLOT_BITS-1:0]   drain_slot;
    logic                            drain_hit;

    // Handshakes toward the input and configuration sides.
    assign in_ready  = (state_reg == S_IDLE) && !back_busy;
    assign cfg_ready = 1'b1;

    // Window classification of the held message.
    assign diff       = item_reg.seq_no - expected_reg;
    assign is_old     = item_reg.seq_no < expected_reg;
    assign is_beyond  = diff >= 32'(sro_pkg::WINDOW);
    assign in_slot    = item_reg.seq_no[sro_pkg::SLOT_BITS-1:0];
    assign store_item = !is_old && !is_beyond && !slot_full_reg[in_slot];
    assign take_route = (item_reg.seq_no > newest_reg) ||
                        ((item_reg.seq_no == newest_reg) && item_reg.from_direct &&
                         !route_direct_reg);

    // Drain of the slot of the expected number; stops when the queue is full.
    assign drain_slot = expected_reg[sro_pkg::SLOT_BITS-1:0];
    assign drain_hit  = slot_full_reg[drain_slot] && !q_full;
    assign q_push     = (state_reg == S_DRAIN) && drain_hit && slot_mem[drain_slot].chat;
    assign q_wdata    = '{seq: expected_reg, payload: slot_mem[drain_slot].payload};

    // Summary handed to the back part.
    assign step_valid = (state_reg == S_DONE);
    assign step_data  = '{status: status_reg, route_updated: updated_reg,
                          next_hop: 8'(hop_reg), expected_seq: expected_reg};

    // Held message and slot contents; payload storage without reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if ((state_reg == S_CLASSIFY) && store_item)
        begin
            slot_mem[in_slot] <= '{payload: item_reg.payload, chat: item_reg.is_chat};
        end
    end

    // Sequencer, route state and slot occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            route_direct_reg <= 1'b0;
            expected_reg     <= 32'd1;
            newest_reg       <= '0;
            hop_reg          <= '0;
            status_reg       <= sro_pkg::ST_ACCEPTED;
            updated_reg      <= 1'b0;
            slot_full_reg    <= '0;
        end
        else
        begin
            // Configuration writes; loading the initial hop also reloads the route.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sro_pkg::CFG_ROUTE_IS_DIRECT: route_direct_reg <= cfg_data[0];
                    sro_pkg::CFG_INITIAL_HOP:
                    begin
                        hop_reg <= cfg_data[sro_pkg::HOP_BITS-1:0];
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        state_reg <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY:
                begin
                    updated_reg <= 1'b0;
                    if (is_old)
                    begin
                        status_reg <= sro_pkg::ST_OLD;
                    end
                    else if (is_beyond)
                    begin
                        status_reg <= sro_pkg::ST_BEYOND;
                    end
                    else if (!store_item)
                    begin
                        status_reg <= sro_pkg::ST_OLD;
                    end
                    else
                    begin
                        status_reg             <= sro_pkg::ST_ACCEPTED;
                        slot_full_reg[in_slot] <= 1'b1;
                        if (take_route)
                        begin
                            newest_reg  <= item_reg.seq_no;
                            hop_reg     <= item_reg.sender_id[sro_pkg::HOP_BITS-1:0];
                            updated_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (drain_hit)
                    begin
                        slot_full_reg[drain_slot] <= 1'b0;
                        if (expected_reg == sro_pkg::SEQ_MAX)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            expected_reg <= expected_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (step_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/sro_back.sv
// Back part: turns a finished message summary and the queued deliveries into
// results, one per cycle while the receiver takes them, through an output register.
// Depends on sro_pkg.
module sro_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_valid,
    output logic                            step_ready,
    input  sro_pkg::step_t                  step_data,
    output logic                            busy,
    output logic                            q_pop,
    input  sro_pkg::dlv_t                   q_rdata,
    input  logic                            q_empty,
    input  logic [sro_pkg::QCNT_BITS-1:0]   q_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sro_pkg::out_item_t              out_data
);

    logic                busy_reg;
    logic                nodlv_reg;
    sro_pkg::step_t      step_reg;
    logic                out_valid_reg;
    sro_pkg::out_item_t  out_reg;
    logic                load;
    logic                last_now;

    assign busy       = busy_reg;
    assign step_ready = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    // A new result is loaded when the output register is free or being emptied.
    assign load     = busy_reg && (!out_valid_reg || out_ready);
    assign q_pop    = load && !nodlv_reg;
    assign last_now = nodlv_reg || (q_count == sro_pkg::QCNT_BITS'(1));

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (step_valid && step_ready)
        begin
            step_reg <= step_data;
        end
        if (load)
        begin
            out_reg.status         <= step_reg.status;
            out_reg.route_updated  <= step_reg.route_updated;
            out_reg.next_hop       <= step_reg.next_hop;
            out_reg.expected_seq   <= step_reg.expected_seq;
            out_reg.last           <= last_now;
            out_reg.delivery_valid <= !nodlv_reg;
            out_reg.delivery_seq     <= nodlv_reg ? '0 : q_rdata.seq;
            out_reg.delivery_payload <= nodlv_reg ? '0 : q_rdata.payload;
        end
    end

    // Busy flag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            nodlv_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_valid && step_ready)
            begin
                busy_reg  <= 1'b1;
                nodlv_reg <= q_empty;
            end
            else if (load && last_now)
            begin
                busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/sro_checker.sv
// Port-level checks for the sequence reorder buffer, bound to the top level.
// Depends on sro_pkg and sequence_reorder_buffer_unit.
module sro_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  sro_pkg::out_item_t out_data
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == sro_pkg::ST_ACCEPTED ||
                       out_data.status == sro_pkg::ST_OLD ||
                       out_data.status == sro_pkg::ST_BEYOND))
        else $error("undefined status code");

    // A result without a delivery is alone, final and carries zero fields.
    a_no_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.delivery_valid |->
            out_data.last && out_data.delivery_seq == '0 &&
            out_data.delivery_payload == '0)
        else $error("empty result malformed");

    // A rejected message never moves the route.
    a_reject_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != sro_pkg::ST_ACCEPTED |-> !out_data.route_updated)
        else $error("route moved by a rejected message");

    // Delivered numbers lie behind the expected number.
    a_delivery_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.delivery_valid |->
            out_data.delivery_seq < out_data.expected_seq ||
            out_data.expected_seq == sro_pkg::SEQ_MAX)
        else $error("delivery ahead of expected number");

endmodule

bind sequence_reorder_buffer_unit sro_checker u_sro_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
